@@ hw/rtl/lgfs_pkg.sv @@
package lgfs_pkg;

   localparam int MAX_DRIVERS         = 4;
   localparam int CHANNELS_PER_DRIVER = 24;
   localparam int STORE_DEPTH         = MAX_DRIVERS * CHANNELS_PER_DRIVER;
   localparam int ADDR_W              = $clog2(STORE_DEPTH);
   localparam int VALUE_W             = 12;
   localparam int COUNT_W             = 7;
   localparam int COUNT_RESET         = 96;
   // wide enough for a group base of target_index * 4 plus three
   localparam int PTR_W               = 9;

   localparam logic [2:0] CMD_WRITE_CH   = 3'd0;
   localparam logic [2:0] CMD_WRITE_RGB  = 3'd1;
   localparam logic [2:0] CMD_WRITE_RGBW = 3'd2;
   localparam logic [2:0] CMD_FILL       = 3'd3;
   localparam logic [2:0] CMD_CLEAR      = 3'd4;
   localparam logic [2:0] CMD_REFRESH    = 3'd5;

   localparam logic [2:0] PERIOD_MONO = 3'd1;
   localparam logic [2:0] PERIOD_RGB  = 3'd3;
   localparam logic [2:0] PERIOD_RGBW = 3'd4;

   typedef struct packed {
      logic [2:0]  command;
      logic [6:0]  target_index;
      logic [2:0]  pattern_period;
      logic [15:0] value_a;
      logic [15:0] value_b;
      logic [15:0] value_c;
      logic [15:0] value_d;
   } req_type;

   typedef struct packed {
      logic [23:0] serial_word;
      logic        last_word;
      logic        value_too_large;
   } rsp_type;

   // sequencer to store
   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [VALUE_W-1:0] wdata;
      logic [ADDR_W-1:0]  raddr_hi;
      logic [ADDR_W-1:0]  raddr_lo;
   } store_req_type;

   // sequencer to output stage, aligned with store read data
   typedef struct packed {
      logic ack;
      logic flag;
      logic rd;
      logic last;
      logic use_hi;
      logic use_lo;
   } evt_type;

   // highest channel sent by a refresh: top channel of the last driver in use
   function automatic logic [PTR_W-1:0] refresh_top(input logic [COUNT_W-1:0] n);
      logic [PTR_W-1:0] top;
      top = PTR_W'(CHANNELS_PER_DRIVER - 1);
      for (int d = 1; d < MAX_DRIVERS; d++) begin
         if (int'(n) > d * CHANNELS_PER_DRIVER) begin
            top = PTR_W'((d + 1) * CHANNELS_PER_DRIVER - 1);
         end
      end
      return top;
   endfunction

endpackage

@@ hw/rtl/lgfs_store.sv @@
module lgfs_store
   import lgfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  store_req_type      req,
   output logic [VALUE_W-1:0] rd_hi,
   output logic [VALUE_W-1:0] rd_lo
);

   logic [VALUE_W-1:0] mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_ff;
   logic [VALUE_W-1:0] q_hi_ff;
   logic [VALUE_W-1:0] q_lo_ff;
   logic vld_hi_ff;
   logic vld_lo_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      q_hi_ff <= mem[req.raddr_hi];
      q_lo_ff <= mem[req.raddr_lo];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         vld_hi_ff <= 1'b0;
         vld_lo_ff <= 1'b0;
      end else begin
         if (req.we) begin
            valid_ff[req.waddr] <= 1'b1;
         end
         vld_hi_ff <= valid_ff[req.raddr_hi];
         vld_lo_ff <= valid_ff[req.raddr_lo];
      end
   end

   assign rd_hi = vld_hi_ff ? q_hi_ff : '0;
   assign rd_lo = vld_lo_ff ? q_lo_ff : '0;

endmodule

@@ hw/rtl/lgfs_seq.sv @@
module lgfs_seq
   import lgfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req,
   input  logic [COUNT_W-1:0] count,
   output logic               busy,
   output store_req_type      st_req,
   output evt_type            evt
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_WRITE   = 2'd1;
   localparam logic [1:0] ST_REFRESH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]         phase_ff, phase_in;
   logic [2:0]         period_ff, period_in;
   logic [VALUE_W-1:0] vals_ff [4];
   logic [VALUE_W-1:0] vals_in [4];
   logic               flag_ff, flag_in;
   evt_type            evt_ff, evt_in;

   logic [COUNT_W-1:0] n_eff;
   logic [PTR_W-1:0]   n_ext;
   logic [PTR_W-1:0]   step;
   logic [PTR_W-1:0]   ptr_sum;
   logic [3:0]         big;
   logic               accept;
   logic               period_ok;
   logic               fill_flag;

   assign n_eff = (count > COUNT_W'(STORE_DEPTH)) ? COUNT_W'(STORE_DEPTH) : count;
   assign n_ext = {{(PTR_W-COUNT_W){1'b0}}, n_eff};

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign big[0] = |req.value_a[15:VALUE_W];
   assign big[1] = |req.value_b[15:VALUE_W];
   assign big[2] = |req.value_c[15:VALUE_W];
   assign big[3] = |req.value_d[15:VALUE_W];

   assign period_ok = (req.pattern_period == PERIOD_MONO) ||
                      (req.pattern_period == PERIOD_RGB) ||
                      (req.pattern_period == PERIOD_RGBW);

   always_comb begin
      case (req.pattern_period)
         PERIOD_MONO: fill_flag = big[0];
         PERIOD_RGB:  fill_flag = |big[2:0];
         PERIOD_RGBW: fill_flag = |big;
         default:     fill_flag = 1'b0;
      endcase
   end

   // the one shared adder: +1 while writing, -2 while refreshing
   assign step    = (state_ff == ST_REFRESH) ? {PTR_W{1'b1}} - PTR_W'(1) : PTR_W'(1);
   assign ptr_sum = ptr_ff + step;

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      period_in = period_ff;
      flag_in   = flag_ff;
      for (int i = 0; i < 4; i++) begin
         vals_in[i] = vals_ff[i];
      end
      evt_in = '0;

      st_req          = '0;
      st_req.waddr    = ptr_ff[ADDR_W-1:0];
      st_req.wdata    = vals_ff[phase_ff];
      st_req.raddr_hi = ptr_ff[ADDR_W-1:0];
      st_req.raddr_lo = {ptr_ff[ADDR_W-1:1], 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in   = '0;
               vals_in[0] = req.value_a[VALUE_W-1:0];
               vals_in[1] = req.value_b[VALUE_W-1:0];
               vals_in[2] = req.value_c[VALUE_W-1:0];
               vals_in[3] = req.value_d[VALUE_W-1:0];
               case (req.command)
                  CMD_WRITE_CH: begin
                     ptr_in    = {2'b00, req.target_index};
                     period_in = PERIOD_MONO;
                     cnt_in    = COUNT_W'(0);
                     flag_in   = big[0];
                     state_in  = ST_WRITE;
                  end
                  CMD_WRITE_RGB: begin
                     ptr_in    = {1'b0, req.target_index, 1'b0} + {2'b00, req.target_index};
                     period_in = PERIOD_RGB;
                     cnt_in    = COUNT_W'(2);
                     flag_in   = |big[2:0];
                     state_in  = ST_WRITE;
                  end
                  CMD_WRITE_RGBW: begin
                     ptr_in    = {req.target_index, 2'b00};
                     period_in = PERIOD_RGBW;
                     cnt_in    = COUNT_W'(3);
                     flag_in   = |big;
                     state_in  = ST_WRITE;
                  end
                  CMD_FILL, CMD_CLEAR: begin
                     if (req.command == CMD_CLEAR) begin
                        for (int i = 0; i < 4; i++) begin
                           vals_in[i] = '0;
                        end
                        period_in = PERIOD_MONO;
                        flag_in   = 1'b0;
                     end else begin
                        period_in = req.pattern_period;
                        flag_in   = fill_flag;
                     end
                     ptr_in = '0;
                     cnt_in = n_eff - COUNT_W'(1);
                     if ((req.command == CMD_FILL && !period_ok) || n_eff == '0) begin
                        // nothing to sweep: acknowledge at once
                        evt_in.ack  = 1'b1;
                        evt_in.flag = (req.command == CMD_FILL) && period_ok && fill_flag;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  CMD_REFRESH: begin
                     ptr_in   = refresh_top(n_eff);
                     state_in = ST_REFRESH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRITE: begin
            st_req.we = (ptr_ff < n_ext);
            ptr_in    = ptr_sum;
            cnt_in    = cnt_ff - COUNT_W'(1);
            phase_in  = ({1'b0, phase_ff} == period_ff - 3'd1) ? 2'd0 : phase_ff + 2'd1;
            if (cnt_ff == '0) begin
               evt_in.ack  = 1'b1;
               evt_in.flag = flag_ff;
               state_in    = ST_IDLE;
            end
         end
         ST_REFRESH: begin
            evt_in.rd     = 1'b1;
            evt_in.use_hi = (ptr_ff < n_ext);
            evt_in.use_lo = (ptr_ff <= n_ext);
            ptr_in        = ptr_sum;
            if (ptr_ff == PTR_W'(1)) begin
               evt_in.last = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         evt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         evt_ff   <= evt_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      cnt_ff    <= cnt_in;
      phase_ff  <= phase_in;
      period_ff <= period_in;
      flag_ff   <= flag_in;
      for (int i = 0; i < 4; i++) begin
         vals_ff[i] <= vals_in[i];
      end
   end

   assign evt = evt_ff;

`ifndef SYNTHESIS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      st_req.we |-> (state_ff == ST_WRITE) && ({1'b0, st_req.waddr} < {1'b0, n_eff}))
      else $error("store write outside channels in use");

   a_refresh_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REFRESH) |-> ptr_ff[0])
      else $error("refresh upper channel is not odd");

   a_ack_alone: assert property (@(posedge clock) disable iff (reset)
      !(evt_ff.ack && evt_ff.rd))
      else $error("acknowledge collides with refresh word");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (evt_in.last && state_ff == ST_REFRESH) |=> (state_ff == ST_IDLE))
      else $error("refresh did not end after last word");
`endif

endmodule

@@ hw/rtl/led_grayscale_frame_serializer.sv @@
// Grayscale store and frame serializer for a chain of 24-channel LED drivers.
// A command is taken when start is high and busy is low; busy then stays high
// until the command's work is done. Write channel writes one channel, RGB
// group three, RGBW group four, fill and clear write the n channels in use,
// and refresh sends one 24-bit word per cycle from a dual read of the channel
// store. Each result passes the event register and then the output register
// and shows on rsp_strobe for exactly one cycle; the receiver cannot stall,
// so it must take every word as it comes. Commands 0 to 4 give one
// acknowledgement, refresh gives 12 words per driver with last_word on the
// latch word, codes 6 and 7 give nothing. The store reads as zero after reset
// with no clearing pass. Write csr_wdata only while the block is idle.
module led_grayscale_frame_serializer
   import lgfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // command transfer
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   // result transfer
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   // channel count register
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   logic [COUNT_W-1:0] count_ff;
   store_req_type      st_req;
   evt_type            evt;
   logic [VALUE_W-1:0] rd_hi;
   logic [VALUE_W-1:0] rd_lo;
   logic               strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   // channel count, reset to the full chain
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(COUNT_RESET);
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // sequencer: command decode, shared address adder, step counter
   lgfs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .count  (count_ff),
      .busy   (busy),
      .st_req (st_req),
      .evt    (evt)
   );

   // channel store, one write and two registered reads per cycle
   lgfs_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .rd_hi (rd_hi),
      .rd_lo (rd_lo)
   );

   // output register: channels not in use go out as zero
   always_comb begin
      rsp_in = '0;
      if (evt.ack) begin
         rsp_in.last_word       = 1'b1;
         rsp_in.value_too_large = evt.flag;
      end else begin
         rsp_in.serial_word = {evt.use_hi ? rd_hi : {VALUE_W{1'b0}},
                               evt.use_lo ? rd_lo : {VALUE_W{1'b0}}};
         rsp_in.last_word   = evt.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= evt.ack || evt.rd;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
   import lgfs_pkg::*;
();

   // codes with no name in the package
   localparam logic [2:0] CMD_RSVD_6  = 3'd6;
   localparam logic [2:0] CMD_RSVD_7  = 3'd7;
   localparam logic [2:0] PERIOD_ZERO = 3'd0;
   localparam logic [2:0] PERIOD_TOP  = 3'd7;

   localparam int LEVEL_MAX   = 4095;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 6;

   // one row of the directed table; typed rows carry their own acknowledgement
   typedef struct packed {
      req_type cmd;
      logic    has_typed;
      rsp_type typed_rsp;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   // shadow copy of the block's state
   logic [VALUE_W-1:0] grayscale_mem [STORE_DEPTH];
   logic [COUNT_W-1:0] chan_count_model;

   rsp_type      pending_words [$];
   stim_row_type directed_rows [$];
   logic         typed_pending;
   rsp_type      typed_value;
   logic         no_gaps;
   int           mismatch_count;
   int           cycle_count;

   led_grayscale_frame_serializer u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic rsp_type make_ack(input logic flag);
      rsp_type w;
      w.serial_word     = '0;
      w.last_word       = 1'b1;
      w.value_too_large = flag;
      return w;
   endfunction

   // channels at or beyond the count go out as zero
   function automatic logic [VALUE_W-1:0] channel_sent(input int ch, input int n);
      if (ch < n) begin
         return grayscale_mem[ch];
      end
      return '0;
   endfunction

   // updates the shadow store and queues the words this command produces
   task automatic predict_command(input req_type r, input logic push_words);
      logic [15:0] vals [4];
      logic        flag;
      rsp_type     w;
      int          n;
      int          width;
      int          base;
      int          per;
      int          drivers;
      int          first;
      int          hi;
      vals[0] = r.value_a;
      vals[1] = r.value_b;
      vals[2] = r.value_c;
      vals[3] = r.value_d;
      n = (int'(chan_count_model) > STORE_DEPTH) ? STORE_DEPTH : int'(chan_count_model);
      flag = 1'b0;
      case (r.command)
         CMD_WRITE_CH: begin
            flag = (vals[0] > LEVEL_MAX);
            if (int'(r.target_index) < n) begin
               grayscale_mem[r.target_index] = vals[0][VALUE_W-1:0];
            end
            if (push_words) pending_words.push_back(make_ack(flag));
         end
         CMD_WRITE_RGB, CMD_WRITE_RGBW: begin
            width = (r.command == CMD_WRITE_RGB) ? 3 : 4;
            base  = int'(r.target_index) * width;
            // each component is dropped on its own once past the count
            for (int i = 0; i < width; i++) begin
               if (vals[i] > LEVEL_MAX) flag = 1'b1;
               if (base + i < n) grayscale_mem[base + i] = vals[i][VALUE_W-1:0];
            end
            if (push_words) pending_words.push_back(make_ack(flag));
         end
         CMD_FILL: begin
            per = int'(r.pattern_period);
            if (r.pattern_period == PERIOD_MONO || r.pattern_period == PERIOD_RGB ||
                r.pattern_period == PERIOD_RGBW) begin
               // only the components the period uses can raise the flag
               for (int i = 0; i < per; i++) begin
                  if (vals[i] > LEVEL_MAX) flag = 1'b1;
               end
               for (int i = 0; i < n; i++) begin
                  grayscale_mem[i] = vals[i % per][VALUE_W-1:0];
               end
            end
            if (push_words) pending_words.push_back(make_ack(flag));
         end
         CMD_CLEAR: begin
            for (int i = 0; i < n; i++) grayscale_mem[i] = '0;
            if (push_words) pending_words.push_back(make_ack(1'b0));
         end
         CMD_REFRESH: begin
            drivers = (n + CHANNELS_PER_DRIVER - 1) / CHANNELS_PER_DRIVER;
            if (drivers == 0) drivers = 1;
            // highest driver first, channel 23 down to 0 inside each driver
            for (int d = drivers; d > 0; d--) begin
               first = (d - 1) * CHANNELS_PER_DRIVER;
               for (int k = 0; k < CHANNELS_PER_DRIVER / 2; k++) begin
                  hi = first + CHANNELS_PER_DRIVER - 1 - 2 * k;
                  w.serial_word     = {channel_sent(hi, n), channel_sent(hi - 1, n)};
                  w.last_word       = (d == 1 && k == CHANNELS_PER_DRIVER / 2 - 1);
                  w.value_too_large = 1'b0;
                  if (push_words) pending_words.push_back(w);
               end
            end
         end
         default: begin
            // reserved codes: no change, no result
         end
      endcase
   endtask

   // monitor: check outgoing words, then track config writes and accepted commands
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) grayscale_mem[i] = '0;
         chan_count_model = COUNT_W'(COUNT_RESET);
      end else begin
         if (rsp_strobe) begin
            if (pending_words.size() == 0) begin
               $display("%0t: word 0x%06h with nothing expected", $time, rsp_data.serial_word);
               mismatch_count++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_data.serial_word !== want.serial_word) begin
                  $display("%0t: serial_word expected 0x%06h actual 0x%06h",
                           $time, want.serial_word, rsp_data.serial_word);
                  mismatch_count++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $display("%0t: last_word expected %0b actual %0b",
                           $time, want.last_word, rsp_data.last_word);
                  mismatch_count++;
               end
               if (rsp_data.value_too_large !== want.value_too_large) begin
                  $display("%0t: value_too_large expected %0b actual %0b",
                           $time, want.value_too_large, rsp_data.value_too_large);
                  mismatch_count++;
               end
            end
         end
         if (csr_we) chan_count_model = csr_wdata;
         // command transfer happens here
         if (start && !busy) begin
            predict_command(req_data, !typed_pending);
            if (typed_pending) pending_words.push_back(typed_value);
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // brightness values that lean on the 12-bit edge
   function automatic logic [15:0] random_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 16'($urandom_range(0, LEVEL_MAX));
      if (r < 75) return 16'($urandom_range(0, 65535));
      if (r < 80) return 16'd0;
      if (r < 87) return 16'd4095;
      if (r < 93) return 16'd4096;
      return 16'hFFFF;
   endfunction

   function automatic req_type random_command();
      req_type r;
      int      sel;
      int      top;
      r.value_a = random_level();
      r.value_b = random_level();
      r.value_c = random_level();
      r.value_d = random_level();
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         r.command = CMD_WRITE_CH;
         top = STORE_DEPTH - 1;
      end else if (sel < 45) begin
         r.command = CMD_WRITE_RGB;
         top = STORE_DEPTH / 3 - 1;
      end else if (sel < 58) begin
         r.command = CMD_WRITE_RGBW;
         top = STORE_DEPTH / 4 - 1;
      end else if (sel < 68) begin
         r.command = CMD_FILL;
         top = 127;
      end else if (sel < 73) begin
         r.command = CMD_CLEAR;
         top = 127;
      end else if (sel < 95) begin
         r.command = CMD_REFRESH;
         top = 127;
      end else begin
         r.command = ($urandom_range(0, 1) == 0) ? CMD_RSVD_6 : CMD_RSVD_7;
         top = 127;
      end
      // most indexes land in the store, some anywhere in the field
      if ($urandom_range(0, 9) == 0) top = 127;
      r.target_index = 7'($urandom_range(0, top));
      sel = $urandom_range(0, 9);
      if (sel < 2) r.pattern_period = 3'($urandom_range(0, 7));
      else if (sel < 5) r.pattern_period = PERIOD_MONO;
      else if (sel < 8) r.pattern_period = PERIOD_RGB;
      else r.pattern_period = PERIOD_RGBW;
      return r;
   endfunction

   function automatic void add_row(input logic [2:0] cmd, input logic [6:0] idx,
                                   input logic [2:0] per, input logic [15:0] a,
                                   input logic [15:0] b, input logic [15:0] c,
                                   input logic [15:0] d, input logic typed,
                                   input logic flag);
      stim_row_type s;
      s.cmd.command        = cmd;
      s.cmd.target_index   = idx;
      s.cmd.pattern_period = per;
      s.cmd.value_a        = a;
      s.cmd.value_b        = b;
      s.cmd.value_c        = c;
      s.cmd.value_d        = d;
      s.has_typed          = typed;
      s.typed_rsp          = make_ack(flag);
      directed_rows.push_back(s);
   endfunction

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic send_command(input req_type cmd, input logic has_typed,
                               input rsp_type typed_rsp);
      int gap;
      req_data      <= cmd;
      typed_pending <= has_typed;
      typed_value   <= typed_rsp;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // block idle: nothing owed and busy low, then a drain wait for the pipeline
   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (pending_words.size() != 0 || busy) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_channel_count(input logic [COUNT_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_counts [10];
      int                 phase_items;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      typed_pending  = 1'b0;
      typed_value    = '0;
      no_gaps        = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;

      // directed table, count at its reset value of 96
      add_row(CMD_REFRESH,    7'd0,   PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0);
      add_row(CMD_WRITE_CH,   7'd0,   PERIOD_ZERO, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, 1);
      add_row(CMD_WRITE_CH,   7'd95,  PERIOD_ZERO, 16'd4095, 16'h0000, 16'h0000, 16'h0000, 1, 0);
      add_row(CMD_WRITE_CH,   7'd1,   PERIOD_ZERO, 16'd4096, 16'h0000, 16'h0000, 16'h0000, 1, 1);
      // index past the store: no write, flag still raised
      add_row(CMD_WRITE_CH,   7'd127, PERIOD_TOP,  16'h1000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
      add_row(CMD_WRITE_CH,   7'd96,  PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0);
      add_row(CMD_WRITE_CH,   7'd64,  PERIOD_MONO, 16'h5AA5, 16'h0000, 16'h0000, 16'h0000, 1, 1);
      add_row(CMD_WRITE_RGB,  7'd0,   PERIOD_ZERO, 16'd1,    16'd2,    16'd3,    16'hFFFF, 1, 0);
      add_row(CMD_WRITE_RGB,  7'd31,  PERIOD_ZERO, 16'h0ABC, 16'h8000, 16'h0000, 16'h0000, 1, 1);
      add_row(CMD_WRITE_RGB,  7'd32,  PERIOD_ZERO, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0000, 1, 0);
      add_row(CMD_WRITE_RGBW, 7'd23,  PERIOD_ZERO, 16'h0123, 16'h0456, 16'h0789, 16'hF000, 1, 1);
      add_row(CMD_WRITE_RGBW, 7'd127, PERIOD_ZERO, 16'h0FFF, 16'h0000, 16'h0FFF, 16'h1000, 1, 1);
      add_row(CMD_WRITE_RGBW, 7'd0,   PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0);
      add_row(CMD_REFRESH,    7'd0,   PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0);
      // mono fill ignores the large second component
      add_row(CMD_FILL,       7'd0,   PERIOD_MONO, 16'h0FFF, 16'hFFFF, 16'h0000, 16'h0000, 1, 0);
      add_row(CMD_REFRESH,    7'd0,   PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0);
      add_row(CMD_FILL,       7'd0,   PERIOD_RGB,  16'd1,    16'd2,    16'h1ABC, 16'h0000, 1, 1);
      add_row(CMD_FILL,       7'd5,   PERIOD_RGBW, 16'h0000, 16'd4095, 16'h0800, 16'h0001, 1, 0);
      add_row(CMD_REFRESH,    7'd0,   PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0);
      // unknown periods: no change, flag low
      add_row(CMD_FILL,       7'd0,   PERIOD_ZERO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
      add_row(CMD_FILL,       7'd0,   PERIOD_TOP,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
      add_row(CMD_REFRESH,    7'd0,   PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0);
      add_row(CMD_CLEAR,      7'd0,   PERIOD_ZERO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
      // reserved codes give no result
      add_row(CMD_RSVD_6,     7'd10,  PERIOD_MONO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
      add_row(CMD_RSVD_7,     7'd10,  PERIOD_MONO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
      add_row(CMD_REFRESH,    7'd0,   PERIOD_ZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0);

      // count settings for the random phases: extremes, driver edges, out of range
      phase_counts[0] = 7'd1;
      phase_counts[1] = 7'd24;
      phase_counts[2] = 7'd25;
      phase_counts[3] = 7'd0;
      phase_counts[4] = 7'd127;
      phase_counts[5] = 7'd100;
      phase_counts[6] = 7'd47;
      phase_counts[7] = 7'($urandom_range(0, 127));
      phase_counts[8] = 7'($urandom_range(1, 96));
      phase_counts[9] = 7'd96;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_command(directed_rows[i].cmd, directed_rows[i].has_typed,
                      directed_rows[i].typed_rsp);
      end
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         write_channel_count(phase_counts[p]);
         // some phases run back to back with no gaps at all
         no_gaps = ($urandom_range(0, 3) == 0);
         phase_items = 10;
         for (int j = 0; j < phase_items; j++) begin
            send_command(random_command(), 1'b0, '0);
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
